// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define SPQ_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// Signal holds while the item is stalled.
`define SPQ_ASSERT_STALL(label, clk, rstn, vld, rdy, sig) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) \
        ((vld) && !(rdy)) |=> $stable(sig)) \
        else $error("stalled item changed");

`endif

// ----- hw/rtl/spq_pkg.sv -----
package spq_pkg;

    localparam int DEPTH     = 16;
    localparam int KEY_WIDTH = 16;
    localparam int TAG_WIDTH = 8;
    localparam int CNT_WIDTH = $clog2(DEPTH + 1);

    typedef logic [KEY_WIDTH-1:0] key_t;
    typedef logic [TAG_WIDTH-1:0] tag_t;
    typedef logic [CNT_WIDTH-1:0] cnt_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_POP    = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic pop;
        key_t key;
        tag_t tag;
    } cell_ctrl_t;

endpackage

// ----- hw/rtl/spq_in_if.sv -----
interface spq_in_if import spq_pkg::*;;
    logic valid;
    logic ready;
    logic opcode;
    logic [KEY_WIDTH-1:0] remaining_time;
    logic [TAG_WIDTH-1:0] task_tag;

    modport source (output valid, opcode, remaining_time, task_tag, input ready);
    modport sink (input valid, opcode, remaining_time, task_tag, output ready);
endinterface

// ----- hw/rtl/spq_out_if.sv -----
interface spq_out_if import spq_pkg::*;;
    logic valid;
    logic ready;
    logic popped_valid;
    logic [TAG_WIDTH-1:0] popped_tag;
    logic [KEY_WIDTH-1:0] popped_time;
    logic [1:0] status;
    logic queue_empty;
    logic queue_full;

    modport source (output valid, popped_valid, popped_tag, popped_time, status,
                    queue_empty, queue_full, input ready);
    modport sink (input valid, popped_valid, popped_tag, popped_time, status,
                  queue_empty, queue_full, output ready);
endinterface

// ----- hw/rtl/sorted_priority_queue.sv -----
// Channel  Role    Payload
// in_ch    sink    opcode, remaining_time, task_tag
// out_ch   source  popped_valid, popped_tag, popped_time, status, queue_empty, queue_full
//
// One item per cycle unless out_ch stalls; cells compare and shift as the item is taken.
// Result is registered; it appears in the cycle after acceptance.
// in_ch.ready is low only while a result waits and out_ch.ready is low.
// rst_n clears the entry count and the output valid; slot contents need no reset.
module sorted_priority_queue import spq_pkg::*;
(
    input logic clk,
    input logic rst_n,
    spq_in_if.sink   in_ch,
    spq_out_if.source out_ch
);

    cnt_t count_reg, count_next;
    logic out_valid_reg;
    logic pvalid_reg;
    tag_t ptag_reg;
    key_t ptime_reg;
    status_t status_reg, status_next;
    logic empty_reg, full_reg;

    logic accept, is_ins, is_full, is_empty;
    cell_ctrl_t ctrl;
    logic [DEPTH-1:0] occ, gt;
    key_t cell_key [DEPTH];
    tag_t cell_tag [DEPTH];

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;
    assign is_ins      = (op_t'(in_ch.opcode) == OP_INSERT);
    assign is_full     = (count_reg == CNT_WIDTH'(DEPTH));
    assign is_empty    = (count_reg == '0);

    assign ctrl.ins = accept && is_ins && !is_full;
    assign ctrl.pop = accept && !is_ins && !is_empty;
    assign ctrl.key = in_ch.remaining_time;
    assign ctrl.tag = in_ch.task_tag;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            assign occ[i] = (CNT_WIDTH'(i) < count_reg);
            spq_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .occ       (occ[i]),
                .prev_gt   ((i == 0) ? 1'b0 : gt[(i == 0) ? 0 : i-1]),
                .left_key  (cell_key[(i == 0) ? 0 : i-1]),
                .left_tag  (cell_tag[(i == 0) ? 0 : i-1]),
                .right_key ((i == DEPTH-1) ? key_t'(0) : cell_key[(i == DEPTH-1) ? i : i+1]),
                .right_tag ((i == DEPTH-1) ? tag_t'(0) : cell_tag[(i == DEPTH-1) ? i : i+1]),
                .gt        (gt[i]),
                .key       (cell_key[i]),
                .tag       (cell_tag[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next  = count_reg;
        status_next = ST_OK;
        if (ctrl.ins)
            count_next = count_reg + 1'b1;
        else if (ctrl.pop)
            count_next = count_reg - 1'b1;
        if (is_ins && is_full)
            status_next = ST_FULL;
        else if (!is_ins && is_empty)
            status_next = ST_EMPTY;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pvalid_reg <= ctrl.pop;
            ptag_reg   <= ctrl.pop ? cell_tag[0] : '0;
            ptime_reg  <= ctrl.pop ? cell_key[0] : '0;
            status_reg <= status_next;
            empty_reg  <= (count_next == '0);
            full_reg   <= (count_next == CNT_WIDTH'(DEPTH));
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.popped_valid = pvalid_reg;
    assign out_ch.popped_tag   = ptag_reg;
    assign out_ch.popped_time  = ptime_reg;
    assign out_ch.status       = status_reg;
    assign out_ch.queue_empty  = empty_reg;
    assign out_ch.queue_full   = full_reg;

endmodule

// ----- hw/rtl/spq_cell.sv -----
module spq_cell import spq_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  logic       occ,
    input  logic       prev_gt,
    input  key_t       left_key,
    input  tag_t       left_tag,
    input  key_t       right_key,
    input  tag_t       right_tag,
    output logic       gt,
    output key_t       key,
    output tag_t       tag
);

    key_t key_reg, key_next;
    tag_t tag_reg, tag_next;

    // slot lies behind the insert point: free, or holds a strictly larger key
    assign gt  = !occ || (key_reg > ctrl.key);
    assign key = key_reg;
    assign tag = tag_reg;

    always_comb
    begin
        key_next = key_reg;
        tag_next = tag_reg;
        if (ctrl.ins && gt)
        begin
            if (prev_gt)
            begin
                key_next = left_key;
                tag_next = left_tag;
            end
            else
            begin
                key_next = ctrl.key;
                tag_next = ctrl.tag;
            end
        end
        else if (ctrl.pop)
        begin
            key_next = right_key;
            tag_next = right_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        tag_reg <= tag_next;
    end

endmodule

// ----- hw/rtl/spq_checker.sv -----
`include "assert_macros.svh"

module spq_checker import spq_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       popped_valid,
    input logic [1:0] status,
    input logic       queue_empty,
    input logic       queue_full
);

    `SPQ_ASSERT(a_full_flag, clk, rst_n, (out_valid && status == ST_FULL) |-> queue_full)
    `SPQ_ASSERT(a_empty_flag, clk, rst_n, (out_valid && status == ST_EMPTY) |-> queue_empty)
    `SPQ_ASSERT(a_pop_ok, clk, rst_n, (out_valid && popped_valid) |-> (status == ST_OK && !queue_full))
    `SPQ_ASSERT_STALL(a_valid_hold, clk, rst_n, out_valid, out_ready, out_valid)
    `SPQ_ASSERT_STALL(a_status_hold, clk, rst_n, out_valid, out_ready, status)

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .popped_valid (out_ch.popped_valid),
    .status       (out_ch.status),
    .queue_empty  (out_ch.queue_empty),
    .queue_full   (out_ch.queue_full)
);
